>>> design/isse_pkg.sv
// Shared types, request codes and sizing helpers for the integer set successor engine.
package isse_pkg;

   localparam int KEY_W = 8;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
   } isse_req_type;

   typedef struct packed {
      logic             key_present;
      logic             next_valid;
      logic [KEY_W-1:0] next_key;
      logic             prev_valid;
      logic [KEY_W-1:0] prev_key;
      logic             set_nonempty;
      logic [KEY_W-1:0] least_key;
      logic [KEY_W-1:0] greatest_key;
   } isse_rsp_type;

   // Request plus the partial answer gathered so far along the cell chain.
   typedef struct packed {
      logic [1:0]       op;
      logic [KEY_W-1:0] key;
      logic             in_range;
      logic             present;
      logic             nv;
      logic [KEY_W-1:0] nk;
      logic             pv;
      logic [KEY_W-1:0] pk;
      logic             ne;
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
   } isse_tok_type;

   // Integer square root, elaboration time only.
   function automatic int isqrt(input int u);
      int r;
      r = 1;
      while ((r + 1) * (r + 1) <= u) begin
         r++;
      end
      return r;
   endfunction

endpackage

>>> design/isse_cell.sv
// One cluster cell: member bits, summary bit, and its share of the scan.
module isse_cell #(
   parameter int UNIVERSE = 256,
   parameter int CL       = 16,
   parameter int IDX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  tok_vld_i,
   input  isse_pkg::isse_tok_type tok_i,
   output logic                  tok_vld_o,
   output isse_pkg::isse_tok_type tok_o
);
   import isse_pkg::*;

   localparam int BASE = IDX * CL;
   localparam int LW   = (CL > 1) ? $clog2(CL) : 1;
   localparam int CMPW = ($clog2(UNIVERSE) + 1 > KEY_W + 1) ? $clog2(UNIVERSE) + 1 : KEY_W + 1;

   logic [CL-1:0]   bits_ff, bits_in;
   logic            summary_ff, summary_in;
   logic            vld_ff;
   isse_tok_type    tok_ff, tok_in;

   logic [CMPW-1:0] key_ext;
   logic            hit;
   logic [LW-1:0]   loc;
   logic [CL-1:0]   gt_mask, lt_mask;
   logic [LW-1:0]   gt_first, lt_last, lo_idx, hi_idx;

   assign key_ext = CMPW'(tok_i.key);
   assign hit     = tok_i.in_range && (key_ext >= CMPW'(BASE)) && (key_ext < CMPW'(BASE + CL));
   assign loc     = LW'(key_ext - CMPW'(BASE));

   always_comb begin
      logic [CMPW-1:0] gidx;
      for (int j = 0; j < CL; j++) begin
         gidx       = CMPW'(BASE + j);
         gt_mask[j] = bits_ff[j] && (gidx > key_ext);
         lt_mask[j] = bits_ff[j] && (gidx < key_ext);
      end
   end

   // lowest / highest set bit encoders
   always_comb begin
      gt_first = '0;
      lo_idx   = '0;
      for (int j = CL - 1; j >= 0; j--) begin
         if (gt_mask[j]) begin
            gt_first = LW'(j);
         end
         if (bits_ff[j]) begin
            lo_idx = LW'(j);
         end
      end
      lt_last = '0;
      hi_idx  = '0;
      for (int j = 0; j < CL; j++) begin
         if (lt_mask[j]) begin
            lt_last = LW'(j);
         end
         if (bits_ff[j]) begin
            hi_idx = LW'(j);
         end
      end
   end

   always_comb begin
      tok_in = tok_i;
      if (hit) begin
         tok_in.present = bits_ff[loc];
      end
      if (summary_ff) begin
         if (!tok_i.ne) begin
            tok_in.lo = KEY_W'(CMPW'(BASE) + CMPW'(lo_idx));
         end
         tok_in.ne = 1'b1;
         tok_in.hi = KEY_W'(CMPW'(BASE) + CMPW'(hi_idx));
      end
      if (!tok_i.nv && (|gt_mask)) begin
         tok_in.nv = 1'b1;
         tok_in.nk = KEY_W'(CMPW'(BASE) + CMPW'(gt_first));
      end
      if (|lt_mask) begin
         tok_in.pv = 1'b1;
         tok_in.pk = KEY_W'(CMPW'(BASE) + CMPW'(lt_last));
      end
   end

   always_comb begin
      bits_in    = bits_ff;
      summary_in = summary_ff;
      if (adv && tok_vld_i && hit) begin
         unique case (tok_i.op)
            OP_INSERT: begin
               bits_in[loc] = 1'b1;
               summary_in   = 1'b1;
            end
            OP_DELETE: begin
               bits_in[loc] = 1'b0;
               summary_in   = |(bits_ff & ~(CL'(1) << loc));
            end
            default: begin
               bits_in    = bits_ff;
               summary_in = summary_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff    <= '0;
         summary_ff <= 1'b0;
         vld_ff     <= 1'b0;
      end else begin
         bits_ff    <= bits_in;
         summary_ff <= summary_in;
         if (adv) begin
            vld_ff <= tok_vld_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_vld_o = vld_ff;
   assign tok_o     = tok_ff;

endmodule

>>> design/integer_set_successor_engine.sv
// Top level of the integer set successor engine: a chain of cluster cells and a result register.
//
//   channel   dir   ports                                   beat
//   req       in    req_valid, req_ready, req_data          one insert, delete or lookup
//   rsp       out   rsp_valid, rsp_ready, rsp_data          one answer per request
//
// A request walks the cell chain, through the register of each of the NCELL cluster cells,
// then lands in the result register.
// A new request enters every cycle, so throughput is one beat per cycle while rsp_ready is high.
// When the result register is full and not taken, the whole chain holds and req_ready drops.
// Synchronous reset empties the set.
module integer_set_successor_engine #(
   parameter int UNIVERSE = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  isse_pkg::isse_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output isse_pkg::isse_rsp_type rsp_data
);
   import isse_pkg::*;

   localparam int CL    = isqrt(UNIVERSE);
   localparam int NCELL = (UNIVERSE + CL - 1) / CL;
   localparam int CMPW  = ($clog2(UNIVERSE) + 1 > KEY_W + 1) ? $clog2(UNIVERSE) + 1 : KEY_W + 1;

   logic         adv;
   logic         vld_chain [0:NCELL];
   isse_tok_type tok_chain [0:NCELL];

   logic         rsp_valid_ff;
   isse_rsp_type rsp_ff, rsp_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      tok_chain[0]          = '0;
      tok_chain[0].op       = req_data.req_type;
      tok_chain[0].key      = req_data.key;
      tok_chain[0].in_range = CMPW'(req_data.key) < CMPW'(UNIVERSE);
   end
   assign vld_chain[0] = req_valid;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      isse_cell #(
         .UNIVERSE (UNIVERSE),
         .CL       (CL),
         .IDX      (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .tok_vld_i (vld_chain[g]),
         .tok_i     (tok_chain[g]),
         .tok_vld_o (vld_chain[g+1]),
         .tok_o     (tok_chain[g+1])
      );
   end

   always_comb begin
      rsp_in.key_present  = tok_chain[NCELL].present;
      rsp_in.next_valid   = tok_chain[NCELL].nv;
      rsp_in.next_key     = tok_chain[NCELL].nk;
      rsp_in.prev_valid   = tok_chain[NCELL].pv;
      rsp_in.prev_key     = tok_chain[NCELL].pk;
      rsp_in.set_nonempty = tok_chain[NCELL].ne;
      rsp_in.least_key    = tok_chain[NCELL].lo;
      rsp_in.greatest_key = tok_chain[NCELL].hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_chain[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_minmax_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.set_nonempty |-> rsp_data.least_key <= rsp_data.greatest_key)
      else $error("least_key above greatest_key");

   a_empty_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.set_nonempty |->
         !rsp_data.key_present && !rsp_data.next_valid && !rsp_data.prev_valid)
      else $error("member reported for empty set");

   a_prev_next_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.next_valid && rsp_data.prev_valid |->
         rsp_data.prev_key < rsp_data.next_key)
      else $error("predecessor not below successor");
`endif

endmodule

>>> bench/integer_set_successor_engine_test.sv
// Self-checking testbench for the integer set successor engine: predicts every answer beat.
module integer_set_successor_engine_test;
   import isse_pkg::*;

   localparam int UNIVERSE = 256;
   localparam int SET_LATENCY = 17;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   isse_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   isse_rsp_type rsp_data;

   logic [UNIVERSE-1:0] member_set = '0;
   isse_rsp_type        answers_pending[$];
   isse_rsp_type        expected_ans;
   int                  error_count = 0;
   int                  idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_request = 0;
   int                  hold_left = 0;
   logic [KEY_W-1:0]    focus_base = '0;

   integer_set_successor_engine #(.UNIVERSE(UNIVERSE)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // answer from the set as it stands, then apply the request's change
   function automatic isse_rsp_type answer_and_update(input isse_req_type r);
      isse_rsp_type a;
      a = '0;
      a.key_present = member_set[r.key];
      for (int i = 0; i < UNIVERSE; i++) begin
         if (member_set[i]) begin
            if (!a.set_nonempty) begin
               a.set_nonempty = 1'b1;
               a.least_key = i[KEY_W-1:0];
            end
            a.greatest_key = i[KEY_W-1:0];
            if (i > r.key && !a.next_valid) begin
               a.next_valid = 1'b1;
               a.next_key = i[KEY_W-1:0];
            end
            if (i < r.key) begin
               a.prev_valid = 1'b1;
               a.prev_key = i[KEY_W-1:0];
            end
         end
      end
      case (r.req_type)
         OP_INSERT: member_set[r.key] = 1'b1;
         OP_DELETE: member_set[r.key] = 1'b0;
         default: ;
      endcase
      return a;
   endfunction

   function automatic isse_req_type random_req(input int insert_pct, input int delete_pct);
      isse_req_type r;
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) begin
         r.req_type = OP_UNKNOWN;
      end else if (roll < 3 + insert_pct) begin
         r.req_type = OP_INSERT;
      end else if (roll < 3 + insert_pct + delete_pct) begin
         r.req_type = OP_DELETE;
      end else begin
         r.req_type = OP_LOOKUP;
      end
      roll = $urandom_range(99);
      if (roll < 60) begin
         r.key = focus_base + 8'($urandom_range(15));
      end else if (roll < 70) begin
         r.key = $urandom_range(1) ? 8'($urandom_range(3)) : 8'(255 - $urandom_range(3));
      end else begin
         r.key = 8'($urandom);
      end
      return r;
   endfunction

   task automatic send_req(input isse_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      answers_pending.push_back(answer_and_update(r));
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (answers_pending.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10) begin
            $display("mismatch %s: expected %0d, got %0d at %0t", field, want, got, $time);
         end
      end
   endtask

   // receiver: random stalls plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset || hold_left > 0) begin
         rsp_ready = 1'b0;
         if (hold_left > 0) hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_pending.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected answer beat at %0t", $time);
         end else begin
            expected_ans = answers_pending.pop_front();
            check_field("key_present", expected_ans.key_present, rsp_data.key_present);
            check_field("next_valid", expected_ans.next_valid, rsp_data.next_valid);
            check_field("next_key", expected_ans.next_key, rsp_data.next_key);
            check_field("prev_valid", expected_ans.prev_valid, rsp_data.prev_valid);
            check_field("prev_key", expected_ans.prev_key, rsp_data.prev_key);
            check_field("set_nonempty", expected_ans.set_nonempty, rsp_data.set_nonempty);
            check_field("least_key", expected_ans.least_key, rsp_data.least_key);
            check_field("greatest_key", expected_ans.greatest_key, rsp_data.greatest_key);
         end
      end
   end

   task automatic test_directed();
      idle_pct = 0;
      stall_pct = 0;
      send_req({OP_LOOKUP, 8'd0});     // empty set
      send_req({OP_LOOKUP, 8'd255});
      send_req({OP_DELETE, 8'd7});     // delete of non-member
      send_req({OP_INSERT, 8'd0});
      send_req({OP_INSERT, 8'd255});
      send_req({OP_INSERT, 8'd255});   // insert of member
      send_req({OP_LOOKUP, 8'd0});
      send_req({OP_LOOKUP, 8'd255});
      send_req({OP_LOOKUP, 8'd128});
      send_req({OP_INSERT, 8'd17});
      send_req({OP_INSERT, 8'd31});
      send_req({OP_DELETE, 8'd17});    // cluster keeps a member
      send_req({OP_DELETE, 8'd31});    // cluster emptied
      send_req({OP_LOOKUP, 8'd20});
      send_req({OP_UNKNOWN, 8'd100});  // unknown type acts as lookup
      send_req({OP_LOOKUP, 8'd100});
      send_req({OP_INSERT, 8'd15});
      send_req({OP_INSERT, 8'd16});
      send_req({OP_LOOKUP, 8'd15});
      send_req({OP_LOOKUP, 8'd16});
      send_req({OP_DELETE, 8'd0});
      send_req({OP_DELETE, 8'd255});
      send_req({OP_DELETE, 8'd15});
      send_req({OP_DELETE, 8'd16});
      send_req({OP_LOOKUP, 8'd8});
      wait_results_drained();
   endtask

   // randomly chosen growth or shrink windows around a moving focus range
   task automatic test_random_traffic(input int items, input int idle, input int stall);
      int grow;
      grow = 1;
      idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         if (n % 100 == 0) grow = $urandom_range(1);
         if ($urandom_range(49) == 0) focus_base = 8'($urandom);
         send_req(grow ? random_req(55, 20) : random_req(20, 55));
      end
      wait_results_drained();
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      send_req(random_req(40, 20));
      hold_request = 300;
      repeat (60) send_req(random_req(40, 20));
      wait_results_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_traffic(440, 0, 0);
      test_backpressure();
      test_random_traffic(440, 83, 0);
      test_random_traffic(440, 0, 83);
      test_random_traffic(440, 31, 31);
      repeat (SET_LATENCY * 2) @(posedge clock);
      if (error_count == 0 && answers_pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
